@@ sv/crccfp_pkg.sv @@
// Shared types, constants and the CRC16 byte update for the CRC checked frame parser.
// No dependencies; imported by crc_checked_frame_parser.
`default_nettype none

package crccfp_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int ADDR_W      = 5;

  localparam logic [7:0]  SYNC_FIRST  = 8'h55;
  localparam logic [7:0]  SYNC_SECOND = 8'hAA;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;

  typedef logic [2:0] status_t;
  localparam status_t STAT_TARGET = 3'd0;
  localparam status_t STAT_STEP   = 3'd1;
  localparam status_t STAT_CRC    = 3'd2;
  localparam status_t STAT_UNSUP  = 3'd3;
  localparam status_t STAT_LEN    = 3'd4;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_TARGET_CMD = 2'd0;
  localparam reg_index_t REG_TARGET_LEN = 2'd1;
  localparam reg_index_t REG_STEP_CMD   = 2'd2;
  localparam reg_index_t REG_STEP_LEN   = 2'd3;

  // One byte of CRC16-CCITT-FALSE, MSB first, no reflection.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/crc_checked_frame_parser.sv @@
// Byte-serial frame parser: header hunt, CRC16 check, payload buffering and replay.
// Depends on crccfp_pkg; payload bytes live in a 32 x 8 synchronous memory.
// A status result is registered as the closing byte is accepted. Throughput: 1 byte per
// cycle while parsing and the output register is free; replay of an N-byte payload does a
// memory read, then an output load, for each byte, input held off meanwhile.
// Reset (synchronous, rst high): hunt restarts, CRC = 0xFFFF, registers to defaults,
// output empty. The payload memory is not cleared; every replayed entry is written by its frame first.
`default_nettype none

module crc_checked_frame_parser #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [7:0]                   s_tdata,   // [7:0] rx_byte
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [15:0]                  m_tdata,   // [7:0] payload_byte, [12:8] byte_index, zero pad
  output crccfp_pkg::status_t          m_tuser,   // [2:0] frame_status
  output logic                         m_tlast,   // last
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  crccfp_pkg::reg_index_t cfg_index,
  input  wire  [7:0]                   cfg_data
);
  import crccfp_pkg::*;

  localparam int LEN_LIMIT = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;

  localparam logic [1:0] ST_PARSE = 2'd0;
  localparam logic [1:0] ST_RD    = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;

  logic [1:0]  state;
  logic [7:0]  target_cmd;
  logic [5:0]  target_len;
  logic [7:0]  step_cmd;
  logic [5:0]  step_len;

  logic [5:0]  parse_position;
  logic [5:0]  expected_length;
  logic [15:0] crc_acc;
  logic [7:0]  command_value;
  logic [5:0]  length_value;
  logic [7:0]  crc_low_byte;

  logic [ADDR_W-1:0] emit_idx;
  status_t           emit_kind;

  logic [7:0] payload_mem [STORE_DEPTH];
  logic [7:0] mem_rdata;

  logic        out_valid;
  status_t     out_status;
  logic [7:0]  out_byte;
  logic [4:0]  out_index;
  logic        out_last;

  logic        out_free;
  logic        in_fire;
  logic [15:0] crc_next;
  logic [6:0]  pos_plus2;
  logic        mem_we;
  logic        emit_last;
  status_t     kind;
  logic        len_err;
  logic        frame_end;
  logic        crc_bad;
  logic        out_load;

  assign out_free  = !out_valid || m_tready;
  assign s_tready  = (state == ST_PARSE) && out_free;
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign crc_next  = crc16_byte(crc_acc, s_tdata);
  assign pos_plus2 = {1'b0, parse_position} + 7'd2;
  assign mem_we    = in_fire && (parse_position >= 6'd4) &&
                     (pos_plus2 < {1'b0, expected_length});
  assign emit_last = ({1'b0, emit_idx} + 6'd1) == length_value;

  assign len_err   = in_fire && (parse_position == 6'd3) && (s_tdata > 8'(LEN_LIMIT));
  assign frame_end = in_fire && (parse_position >= 6'd4) &&
                     (pos_plus2 > {1'b0, expected_length});
  assign crc_bad   = {s_tdata, crc_low_byte} != crc_acc;
  assign out_load  = len_err ||
                     (frame_end && (crc_bad || kind == STAT_UNSUP || length_value == 6'd0)) ||
                     ((state == ST_OUT) && out_free);

  always_comb begin
    if (command_value == target_cmd && length_value == target_len) begin
      kind = STAT_TARGET;
    end else if (command_value == step_cmd && length_value == step_len) begin
      kind = STAT_STEP;
    end else begin
      kind = STAT_UNSUP;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {3'b000, out_index, out_byte};
  assign m_tlast  = out_last;

  // Writes happen only while parsing and reads only while replaying, so the
  // two ports never touch the memory in the same cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_mem[ADDR_W'(parse_position - 6'd4)] <= s_tdata;
    end
    if (state == ST_RD) begin
      mem_rdata <= payload_mem[emit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_PARSE;
      target_cmd      <= 8'd1;
      target_len      <= 6'd12;
      step_cmd        <= 8'd2;
      step_len        <= 6'd8;
      parse_position  <= '0;
      expected_length <= '0;
      crc_acc         <= CRC_INIT;
      command_value   <= '0;
      length_value    <= '0;
      crc_low_byte    <= '0;
      emit_idx        <= '0;
      emit_kind       <= STAT_TARGET;
      out_valid       <= 1'b0;
      out_status      <= STAT_TARGET;
      out_byte        <= '0;
      out_index       <= '0;
      out_last        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_CMD: target_cmd <= cfg_data;
          REG_TARGET_LEN: target_len <= cfg_data[5:0];
          REG_STEP_CMD:   step_cmd   <= cfg_data;
          REG_STEP_LEN:   step_len   <= cfg_data[5:0];
          default: ;
        endcase
      end

      // load a new result, else retire the accepted one
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_PARSE: begin
          if (in_fire) begin
            if (parse_position == 6'd0) begin
              if (s_tdata == SYNC_FIRST) begin
                parse_position <= 6'd1;
              end
            end else if (parse_position == 6'd1) begin
              if (s_tdata == SYNC_SECOND) begin
                parse_position <= 6'd2;
                crc_acc        <= CRC_INIT;
              end else if (s_tdata != SYNC_FIRST) begin
                parse_position  <= '0;
                expected_length <= '0;
                crc_acc         <= CRC_INIT;
              end
            end else if (parse_position == 6'd2) begin
              command_value  <= s_tdata;
              crc_acc        <= crc_next;
              parse_position <= 6'd3;
            end else if (parse_position == 6'd3) begin
              if (s_tdata > 8'(LEN_LIMIT)) begin
                parse_position  <= '0;
                expected_length <= '0;
                crc_acc         <= CRC_INIT;
                out_status      <= STAT_LEN;
                out_byte        <= '0;
                out_index       <= '0;
                out_last        <= 1'b1;
              end else begin
                length_value    <= s_tdata[5:0];
                expected_length <= s_tdata[5:0] + 6'd6;
                crc_acc         <= crc_next;
                parse_position  <= 6'd4;
              end
            end else if (pos_plus2 < {1'b0, expected_length}) begin
              crc_acc        <= crc_next;
              parse_position <= parse_position + 6'd1;
            end else if (pos_plus2 == {1'b0, expected_length}) begin
              crc_low_byte   <= s_tdata;
              parse_position <= parse_position + 6'd1;
            end else begin
              // closing CRC byte: check, classify, restart the hunt; a good payload starts replay
              parse_position  <= '0;
              expected_length <= '0;
              crc_acc         <= CRC_INIT;
              if (crc_bad) begin
                out_status <= STAT_CRC;
                out_byte   <= '0;
                out_index  <= '0;
                out_last   <= 1'b1;
              end else if (kind == STAT_UNSUP || length_value == 6'd0) begin
                out_status <= kind;
                out_byte   <= '0;
                out_index  <= '0;
                out_last   <= 1'b1;
              end else begin
                emit_kind <= kind;
                emit_idx  <= '0;
                state     <= ST_RD;
              end
            end
          end
        end
        ST_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          // hold the read data until the output register frees up
          if (out_free) begin
            out_status <= emit_kind;
            out_byte   <= mem_rdata;
            out_index  <= emit_idx;
            out_last   <= emit_last;
            emit_idx   <= emit_idx + 1'b1;
            state      <= emit_last ? ST_PARSE : ST_RD;
          end
        end
        default: begin
          state <= ST_PARSE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_error_results_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == STAT_CRC || m_tuser == STAT_UNSUP || m_tuser == STAT_LEN))
      |-> (m_tlast && m_tdata == 16'h0000))
    else $error("error result not marked last or carries data");

  a_no_write_during_replay: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_PARSE))
    else $error("payload memory written during replay");

  a_replay_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_OUT && state == ST_PARSE) |-> (m_tvalid && m_tlast))
    else $error("replay ended without a last byte");

  a_frame_length_bound: assert property (@(posedge clk) disable iff (rst)
    (parse_position >= 6'd4) |-> (expected_length <= 6'(6 + LEN_LIMIT)))
    else $error("expected frame length beyond limit");
`endif

endmodule

`default_nettype wire
